### hdl/arpss_pkg.sv
// Shared codes, types and default sizes for the arpeggio step sequencer.
package arpss_pkg;

    typedef logic [2:0] t_mode;
    typedef logic       t_op;

    localparam t_mode M_UP      = 3'd0;
    localparam t_mode M_DOWN    = 3'd1;
    localparam t_mode M_UPDOWN1 = 3'd2;
    localparam t_mode M_DOWNUP1 = 3'd3;
    localparam t_mode M_UPDOWN2 = 3'd4;
    localparam t_mode M_DOWNUP2 = 3'd5;
    localparam t_mode M_RANDOM  = 3'd6;

    localparam t_op OP_ADVANCE = 1'b0;
    localparam t_op OP_RESET   = 1'b1;

    localparam int NOTE_SLOTS_DEF = 16;
    localparam int MAX_SPAN_DEF   = 3;

endpackage

### hdl/arpss_step.sv
// Sequencer state registers and the next-position logic for one item.
module arpss_step
    import arpss_pkg::*;
#(
    parameter int NOTE_SLOTS = NOTE_SLOTS_DEF,
    parameter int MAX_SPAN   = MAX_SPAN_DEF,
    localparam int CW = $clog2(NOTE_SLOTS + 1),
    localparam int SW = $clog2(NOTE_SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  t_op           i_operation,
    input  t_mode         i_play_mode,
    input  logic [1:0]    i_octave_span,
    input  logic [CW-1:0] i_note_count,
    input  logic [SW-1:0] i_random_note,
    input  logic [1:0]    i_random_octave,
    output logic [SW-1:0] o_note_slot,
    output logic [1:0]    o_octave_offset,
    output logic          o_has_notes
);

    localparam int SPW = $clog2(MAX_SPAN + 1);
    localparam int PW  = $clog2(NOTE_SLOTS + 2) + 1;
    localparam int OW  = $clog2(MAX_SPAN + 2) + 2;

    localparam logic signed [PW-1:0] P_ZERO = '0;
    localparam logic signed [PW-1:0] P_ONE  = PW'(1);
    localparam logic signed [PW-1:0] P_M1   = -PW'(1);
    localparam logic signed [PW-1:0] P_M2   = -PW'(2);
    localparam logic signed [OW-1:0] O_ZERO = '0;
    localparam logic signed [OW-1:0] O_ONE  = OW'(1);
    localparam logic signed [OW-1:0] O_TOP  = OW'(3);
    localparam logic signed [OW-1:0] O_MAX  = OW'(MAX_SPAN);
    localparam logic signed [1:0]    D_PLUS  = 2'sd1;
    localparam logic signed [1:0]    D_MINUS = -2'sd1;
    localparam logic signed [1:0]    D_HOLD  = 2'sd0;

    t_mode                  r_mode, n_mode;
    logic [SPW-1:0]         r_span, n_span;
    logic signed [1:0]      r_dir, n_dir;
    logic signed [PW-1:0]   r_pos, n_pos;
    logic signed [OW-1:0]   r_oct, n_oct;

    t_mode                  mode_sat;
    logic [CW-1:0]          cnt_sat;
    logic signed [PW-1:0]   cnt;
    logic signed [PW-1:0]   rnd_note;
    logic signed [OW-1:0]   rnd_oct;
    logic signed [OW-1:0]   span_in;
    logic signed [OW-1:0]   span_sat;
    logic signed [OW-1:0]   span_old;

    always_comb begin
        mode_sat = (i_play_mode > M_RANDOM) ? M_RANDOM : i_play_mode;
        cnt_sat  = (i_note_count > CW'(NOTE_SLOTS)) ? CW'(NOTE_SLOTS) : i_note_count;
        cnt      = signed'({{(PW - CW){1'b0}}, cnt_sat});
        rnd_note = signed'({{(PW - SW){1'b0}}, i_random_note});
        rnd_oct  = signed'({{(OW - 2){1'b0}}, i_random_octave});
        span_in  = signed'({{(OW - 2){1'b0}}, i_octave_span});
        span_sat = (span_in > O_MAX) ? O_MAX : span_in;
        span_old = signed'({{(OW - SPW){1'b0}}, r_span});

        n_mode = r_mode;
        n_span = r_span;
        n_dir  = r_dir;
        n_pos  = r_pos;
        n_oct  = r_oct;

        if (i_operation == OP_RESET) begin
            unique case (r_mode)
                M_UP, M_UPDOWN1, M_UPDOWN2: begin
                    n_pos = P_M1;
                    n_oct = O_ZERO;
                    n_dir = D_PLUS;
                end
                M_DOWN, M_DOWNUP1, M_DOWNUP2: begin
                    n_pos = P_M2;
                    n_oct = span_old;
                    n_dir = D_MINUS;
                end
                default: begin
                    n_pos = P_ZERO;
                    n_oct = O_ZERO;
                    n_dir = D_HOLD;
                end
            endcase
        end else begin
            if (mode_sat != r_mode) begin
                unique case (mode_sat)
                    M_UP:   n_dir = D_PLUS;
                    M_DOWN: n_dir = D_MINUS;
                    M_RANDOM: n_dir = D_HOLD;
                    M_UPDOWN1, M_UPDOWN2: begin
                        if (n_dir == D_HOLD) n_dir = D_PLUS;
                    end
                    default: begin
                        if (n_dir == D_HOLD) n_dir = D_MINUS;
                    end
                endcase
                n_mode = mode_sat;
            end
            n_span = span_sat[SPW-1:0];

            if (n_pos < P_M1) n_pos = cnt;
            n_pos = n_pos + PW'(n_dir);

            unique case (n_mode)
                M_UP: begin
                    if (n_pos >= cnt) begin
                        n_pos = P_ZERO;
                        n_oct = n_oct + OW'(n_dir);
                    end
                    if (n_pos < P_ZERO) n_pos = P_ZERO;
                    if (n_oct > span_sat) n_oct = O_ZERO;
                end
                M_DOWN: begin
                    if (n_pos < P_ZERO) begin
                        n_pos = cnt - P_ONE;
                        n_oct = n_oct + OW'(n_dir);
                    end
                    if (n_pos > cnt - P_ONE) n_pos = cnt - P_ONE;
                    if (n_oct < O_ZERO) n_oct = span_sat;
                end
                M_UPDOWN1, M_DOWNUP1: begin
                    if (n_oct >= span_sat && n_pos >= cnt - P_ONE) n_dir = D_MINUS;
                    if (n_pos >= cnt) begin
                        n_pos = P_ZERO;
                        if (n_oct < span_sat) n_oct = n_oct + OW'(n_dir);
                    end
                    if (n_oct <= O_ZERO && n_pos < P_ONE) n_dir = D_PLUS;
                    if (n_pos < P_ZERO) begin
                        n_pos = cnt - P_ONE;
                        if (n_oct >= O_ZERO) n_oct = n_oct + OW'(n_dir);
                    end
                end
                M_UPDOWN2, M_DOWNUP2: begin
                    if (n_pos >= cnt && n_oct > span_sat - O_ONE) begin
                        n_pos = n_pos - PW'(n_dir);
                        n_dir = D_MINUS;
                    end
                    if (n_pos >= cnt) begin
                        n_pos = P_ZERO;
                        if (n_oct < span_sat) n_oct = n_oct + OW'(n_dir);
                    end
                    if (n_pos < P_ZERO && n_oct < O_ONE) begin
                        n_pos = n_pos + P_ONE;
                        n_dir = D_PLUS;
                    end
                    if (n_pos < P_ZERO) begin
                        n_pos = cnt - P_ONE;
                        if (n_oct > O_ZERO) n_oct = n_oct + OW'(n_dir);
                    end
                end
                default: begin
                    if (cnt == P_ZERO) begin
                        n_pos = P_ZERO;
                    end else begin
                        n_pos = (rnd_note < cnt - P_ONE) ? rnd_note : cnt - P_ONE;
                    end
                    n_oct = (rnd_oct < span_sat) ? rnd_oct : span_sat;
                end
            endcase

            if (n_oct > span_sat) n_oct = span_sat;
        end
    end

    always_comb begin
        if (cnt == P_ZERO || n_pos < P_ZERO) begin
            o_note_slot = '0;
        end else if (n_pos < cnt) begin
            o_note_slot = n_pos[SW-1:0];
        end else begin
            o_note_slot = cnt_sat[SW-1:0] - SW'(1);
        end

        if (n_oct < O_ZERO) begin
            o_octave_offset = 2'd0;
        end else if (n_oct > O_TOP) begin
            o_octave_offset = 2'd3;
        end else begin
            o_octave_offset = n_oct[1:0];
        end

        o_has_notes = (cnt != P_ZERO);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_UP;
            r_span <= '0;
            r_dir  <= D_PLUS;
            r_pos  <= P_ZERO;
            r_oct  <= O_ZERO;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_span <= n_span;
            r_dir  <= n_dir;
            r_pos  <= n_pos;
            r_oct  <= n_oct;
        end
    end

endmodule

### hdl/arpeggio_step_sequencer_core.sv
// Top level of the arpeggio step sequencer: input register, step logic, result register.
//
//  Channel  Valid    Stall    Payload
//  input    i_valid  o_stall  i_operation, i_play_mode, i_octave_span, i_note_count,
//                             i_random_note, i_random_octave
//  result   o_valid  i_stall  o_note_slot, o_octave_offset, o_has_notes
//
// One item is accepted per cycle while not stalled; its result is registered on fire.
// The step logic between the input register and the result register updates the
// sequencer state once per item, which sets the rate of one item per cycle when unstalled.
// Reset is synchronous and active low; it empties both registers and restores the state.
// A stalled result holds the input register, and the input stalls only while both are full.
module arpeggio_step_sequencer_core
    import arpss_pkg::*;
#(
    parameter int NOTE_SLOTS = NOTE_SLOTS_DEF,
    parameter int MAX_SPAN   = MAX_SPAN_DEF,
    localparam int CW = $clog2(NOTE_SLOTS + 1),
    localparam int SW = $clog2(NOTE_SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_operation,
    input  logic [2:0]    i_play_mode,
    input  logic [1:0]    i_octave_span,
    input  logic [CW-1:0] i_note_count,
    input  logic [SW-1:0] i_random_note,
    input  logic [1:0]    i_random_octave,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [SW-1:0] o_note_slot,
    output logic [1:0]    o_octave_offset,
    output logic          o_has_notes
);

    logic          r_in_valid, n_in_valid;
    t_op           r_operation;
    t_mode         r_play_mode;
    logic [1:0]    r_octave_span;
    logic [CW-1:0] r_note_count;
    logic [SW-1:0] r_random_note;
    logic [1:0]    r_random_octave;

    logic          r_out_valid, n_out_valid;
    logic [SW-1:0] r_note_slot;
    logic [1:0]    r_octave_offset;
    logic          r_has_notes;

    logic          out_free;
    logic          fire;
    logic          in_accept;
    logic [SW-1:0] step_slot;
    logic [1:0]    step_octave;
    logic          step_has_notes;

    assign out_free  = !r_out_valid || !i_stall;
    assign fire      = r_in_valid && out_free;
    assign o_stall   = r_in_valid && !out_free;
    assign in_accept = i_valid && !o_stall;

    assign n_in_valid  = in_accept ? 1'b1 : (fire ? 1'b0 : r_in_valid);
    assign n_out_valid = fire ? 1'b1 : (out_free ? 1'b0 : r_out_valid);

    arpss_step #(
        .NOTE_SLOTS (NOTE_SLOTS),
        .MAX_SPAN   (MAX_SPAN)
    ) u_step (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_operation     (r_operation),
        .i_play_mode     (r_play_mode),
        .i_octave_span   (r_octave_span),
        .i_note_count    (r_note_count),
        .i_random_note   (r_random_note),
        .i_random_octave (r_random_octave),
        .o_note_slot     (step_slot),
        .o_octave_offset (step_octave),
        .o_has_notes     (step_has_notes)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_operation     <= i_operation;
            r_play_mode     <= i_play_mode;
            r_octave_span   <= i_octave_span;
            r_note_count    <= i_note_count;
            r_random_note   <= i_random_note;
            r_random_octave <= i_random_octave;
        end
        if (fire) begin
            r_note_slot     <= step_slot;
            r_octave_offset <= step_octave;
            r_has_notes     <= step_has_notes;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_note_slot     = r_note_slot;
    assign o_octave_offset = r_octave_offset;
    assign o_has_notes     = r_has_notes;

endmodule

### sim/tb.sv
// Self-checking testbench for the arpeggio step sequencer core, with a built-in step predictor.
`timescale 1ns / 1ps

module tb;
    import arpss_pkg::*;

    localparam int NOTES = NOTE_SLOTS_DEF;
    localparam int SPAN_MAX = MAX_SPAN_DEF;
    localparam int CW = $clog2(NOTES + 1);
    localparam int SW = $clog2(NOTES);
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1250;

    typedef struct packed {
        logic [SW-1:0] slot;
        logic [1:0]    octave;
        logic          has_notes;
    } t_arp_step;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    logic          i_operation = OP_ADVANCE;
    logic [2:0]    i_play_mode = M_UP;
    logic [1:0]    i_octave_span = '0;
    logic [CW-1:0] i_note_count = '0;
    logic [SW-1:0] i_random_note = '0;
    logic [1:0]    i_random_octave = '0;
    logic          o_valid;
    logic          i_stall = 1'b0;
    logic [SW-1:0] o_note_slot;
    logic [1:0]    o_octave_offset;
    logic          o_has_notes;

    t_arp_step pending_steps[$];

    int arp_mode;
    int arp_span;
    int arp_dir;
    int arp_pos;
    int arp_oct;

    int cycles;
    int errors;
    int items_sent;
    int resets_sent;
    int steps_checked;
    bit calm_input;
    bit calm_output;
    int stall_left;

    arpeggio_step_sequencer_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_play_mode    (i_play_mode),
        .i_octave_span  (i_octave_span),
        .i_note_count   (i_note_count),
        .i_random_note  (i_random_note),
        .i_random_octave(i_random_octave),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_note_slot    (o_note_slot),
        .o_octave_offset(o_octave_offset),
        .o_has_notes    (o_has_notes)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall = 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall = 1'b1;
        end else begin
            stall_left = pick_gap(calm_output);
            i_stall = (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    task automatic arp_restart();
        case (arp_mode)
            int'(M_UP), int'(M_UPDOWN1), int'(M_UPDOWN2): begin
                arp_pos = -1; arp_oct = 0; arp_dir = 1;
            end
            int'(M_DOWN), int'(M_DOWNUP1), int'(M_DOWNUP2): begin
                arp_pos = -2; arp_oct = arp_span; arp_dir = -1;
            end
            default: begin
                arp_pos = 0; arp_oct = 0; arp_dir = 0;
            end
        endcase
    endtask

    task automatic arp_change_mode(int m);
        if (arp_mode != m) begin
            case (m)
                int'(M_UP):     arp_dir = 1;
                int'(M_DOWN):   arp_dir = -1;
                int'(M_RANDOM): arp_dir = 0;
                int'(M_UPDOWN1), int'(M_UPDOWN2): begin
                    if (arp_dir == 0) arp_dir = 1;
                end
                default: begin
                    if (arp_dir == 0) arp_dir = -1;
                end
            endcase
            arp_mode = m;
        end
    endtask

    task automatic arp_advance(int n, int rnd_note, int rnd_oct);
        int r;
        r = arp_span;
        if (arp_pos < -1) arp_pos = n;
        arp_pos += arp_dir;
        case (arp_mode)
            int'(M_UP): begin
                if (arp_pos >= n) begin
                    arp_pos = 0;
                    arp_oct += arp_dir;
                end
                if (arp_pos < 0) arp_pos = 0;
                if (arp_oct > r) arp_oct = 0;
            end
            int'(M_DOWN): begin
                if (arp_pos < 0) begin
                    arp_pos = n - 1;
                    arp_oct += arp_dir;
                end
                if (arp_pos > n - 1) arp_pos = n - 1;
                if (arp_oct < 0) arp_oct = r;
            end
            int'(M_UPDOWN1), int'(M_DOWNUP1): begin
                if (arp_oct >= r && arp_pos >= n - 1) arp_dir = -1;
                if (arp_pos >= n) begin
                    arp_pos = 0;
                    if (arp_oct < r) arp_oct += arp_dir;
                end
                if (arp_oct <= 0 && arp_pos < 1) arp_dir = 1;
                if (arp_pos < 0) begin
                    arp_pos = n - 1;
                    if (arp_oct >= 0) arp_oct += arp_dir;
                end
            end
            int'(M_UPDOWN2), int'(M_DOWNUP2): begin
                if (arp_pos >= n && arp_oct > r - 1) begin
                    arp_pos -= arp_dir;
                    arp_dir = -1;
                end
                if (arp_pos >= n) begin
                    arp_pos = 0;
                    if (arp_oct < r) arp_oct += arp_dir;
                end
                if (arp_pos < 0 && arp_oct < 1) begin
                    arp_pos += 1;
                    arp_dir = 1;
                end
                if (arp_pos < 0) begin
                    arp_pos = n - 1;
                    if (arp_oct > 0) arp_oct += arp_dir;
                end
            end
            default: begin
                arp_pos = (n == 0) ? 0 : ((rnd_note < n - 1) ? rnd_note : n - 1);
                arp_oct = (rnd_oct < r) ? rnd_oct : r;
            end
        endcase
        if (arp_oct > r) arp_oct = r;
    endtask

    task automatic arp_predict(input logic op, input logic [2:0] mode_in,
                               input logic [1:0] span_in, input logic [CW-1:0] n_in,
                               input logic [SW-1:0] rn_in, input logic [1:0] ro_in,
                               output t_arp_step step);
        int m;
        int span;
        int n;
        int slot;
        int oct;
        m = int'(mode_in);
        span = int'(span_in);
        n = int'(n_in);
        if (m > int'(M_RANDOM)) m = int'(M_RANDOM);
        if (span > SPAN_MAX) span = SPAN_MAX;
        if (n > NOTES) n = NOTES;
        if (op == OP_RESET) begin
            arp_restart();
        end else begin
            arp_change_mode(m);
            arp_span = span;
            arp_advance(n, int'(rn_in), int'(ro_in));
        end
        if (n == 0 || arp_pos < 0) slot = 0;
        else if (arp_pos < n) slot = arp_pos;
        else slot = n - 1;
        oct = arp_oct;
        if (oct < 0) oct = 0;
        if (oct > 3) oct = 3;
        step.slot = slot[SW-1:0];
        step.octave = oct[1:0];
        step.has_notes = (n != 0);
    endtask

    task automatic send_item(logic op, logic [2:0] mode, logic [1:0] span,
                             logic [CW-1:0] n, logic [SW-1:0] rn, logic [1:0] ro);
        int gap;
        t_arp_step step;
        gap = pick_gap(calm_input);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_operation = op;
        i_play_mode = mode;
        i_octave_span = span;
        i_note_count = n;
        i_random_note = rn;
        i_random_octave = ro;
        do @(posedge i_clk); while (o_stall);
        arp_predict(op, mode, span, n, rn, ro, step);
        pending_steps.insert(pending_steps.size(), step);
        items_sent++;
        if (op == OP_RESET) resets_sent++;
    endtask

    task automatic advance_item(logic [2:0] mode, logic [1:0] span, logic [CW-1:0] n);
        send_item(OP_ADVANCE, mode, span, n, SW'($urandom_range(0, 15)),
                  2'($urandom_range(0, 3)));
    endtask

    always @(posedge i_clk) begin
        t_arp_step want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_steps.size() == 0) begin
                $error("result with no expected step: slot %0d octave %0d has_notes %0d",
                       o_note_slot, o_octave_offset, o_has_notes);
                errors++;
            end else begin
                want = pending_steps.pop_front();
                steps_checked++;
                if (o_note_slot !== want.slot) begin
                    $error("note_slot expected %0d actual %0d", want.slot, o_note_slot);
                    errors++;
                end
                if (o_octave_offset !== want.octave) begin
                    $error("octave_offset expected %0d actual %0d", want.octave,
                           o_octave_offset);
                    errors++;
                end
                if (o_has_notes !== want.has_notes) begin
                    $error("has_notes expected %0d actual %0d", want.has_notes, o_has_notes);
                    errors++;
                end
            end
        end
    end

    task automatic test_edges();
        calm_input = 1'b0;
        calm_output = 1'b0;
        advance_item(M_UP, 2'd0, 5'd0);
        send_item(OP_RESET, M_UP, 2'd0, 5'd0, 4'd0, 2'd0);
        advance_item(M_UP, 2'd3, 5'd16);
        advance_item(M_DOWN, 2'd3, 5'd16);
        send_item(OP_ADVANCE, 3'd7, 2'd3, 5'd31, 4'd15, 2'd3);
        send_item(OP_ADVANCE, M_RANDOM, 2'd1, 5'd5, 4'd15, 2'd3);
        send_item(OP_ADVANCE, M_RANDOM, 2'd2, 5'd0, 4'd9, 2'd0);
        send_item(OP_RESET, M_RANDOM, 2'd0, 5'd4, 4'd0, 2'd0);
        send_item(OP_ADVANCE, M_RANDOM, 2'd3, 5'd16, 4'd15, 2'd2);
    endtask

    task automatic test_each_mode();
        for (int m = int'(M_UP); m <= int'(M_DOWNUP2); m++) begin
            advance_item(m[2:0], 2'd1, 5'd2);
            send_item(OP_RESET, m[2:0], 2'd1, 5'd2, 4'd0, 2'd0);
            advance_item(m[2:0], 2'd1, 5'd2);
        end
    endtask

    task automatic test_random_phrases();
        int target;
        int len;
        int r;
        logic [2:0] mode;
        logic [1:0] span;
        logic [CW-1:0] n;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            calm_input = ($urandom_range(0, 4) == 0);
            calm_output = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 85) begin
                mode = 3'($urandom_range(0, 7));
                span = 2'($urandom_range(0, 3));
                r = $urandom_range(0, 99);
                if (r < 8) n = '0;
                else if (r < 16) n = CW'($urandom_range(17, 31));
                else n = CW'($urandom_range(1, 16));
                len = $urandom_range(5, 60);
                if ($urandom_range(0, 1) != 0) send_item(OP_RESET, mode, span, n, '0, '0);
                repeat (len) begin
                    r = $urandom_range(0, 99);
                    if (r < 5) begin
                        send_item(OP_RESET, 3'($urandom_range(0, 7)),
                                  2'($urandom_range(0, 3)), n,
                                  SW'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
                    end else begin
                        if (r < 12) n = CW'($urandom_range(0, 31));
                        else if (r < 16) span = 2'($urandom_range(0, 3));
                        else if (r < 19) mode = 3'($urandom_range(0, 7));
                        advance_item(mode, span, n);
                    end
                end
            end else begin
                repeat ($urandom_range(1, 10)) begin
                    send_item(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                              2'($urandom_range(0, 3)), CW'($urandom_range(0, 31)),
                              SW'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
                end
            end
        end
    endtask

    initial begin
        arp_mode = int'(M_UP);
        arp_span = 0;
        arp_dir = 1;
        arp_pos = 0;
        arp_oct = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_edges();
        test_each_mode();
        test_random_phrases();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_steps.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d items (%0d position resets) across all play modes and spans.",
                 items_sent, resets_sent);
        $display("Checked %0d results with random gaps and stalls on both channels.",
                 steps_checked);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/arpss_pkg.sv
hdl/arpss_step.sv
hdl/arpeggio_step_sequencer_core.sv
sim/tb.sv
